// ----- rtl/mbs_pkg.sv -----
// mbs_pkg: shared types and constants for the meshlet bounding sphere block
// no dependencies
package mbs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PASS,
        ST_DRAIN,
        ST_SQRT,
        ST_OUT
    } mbs_state_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_INDEX = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept;     // input item taken, latch it
        logic vs_write;   // not used; vertex store writes happen on accept
        logic box_update; // fold looked-up position into box
        logic pass_start; // clear radius pass counters
        logic pass_step;  // issue one radius pass read
        logic sqrt_start;
        logic sqrt_step;
        logic finish;     // publish result, clear meshlet state
    } mbs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_index;
        logic meshlet_done;
        logic pass_last;
        logic sqrt_last;
    } mbs_status_t;

endpackage

// ----- rtl/mbs_datapath.sv -----
// mbs_datapath: vertex store, index store, box, distance pass and square root
// depends on mbs_pkg
module mbs_datapath #(
    parameter int MAX_TRIANGLES = 126,
    parameter int VERTEX_DEPTH  = 4096,
    parameter int COORD_BITS    = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mbs_pkg::mbs_cmd_t       cmd,
    output mbs_pkg::mbs_status_t    status,
    input  logic                    op,
    input  logic [11:0]             vertex_index,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic                    end_of_list,
    input  logic [12:0]             cfg_value,
    output logic [31:0]             prim_offset,
    output logic [6:0]              prim_count,
    output logic [12:0]             mesh_vertices,
    output logic signed [COORD_BITS-1:0] center_x,
    output logic signed [COORD_BITS-1:0] center_y,
    output logic signed [COORD_BITS-1:0] center_z,
    output logic [25:0]             radius
);
    import mbs_pkg::*;

    localparam int CHUNK_LEN = MAX_TRIANGLES * 3;
    localparam int CW  = $clog2(CHUNK_LEN + 1);
    localparam int CA  = $clog2(CHUNK_LEN);
    // a 12-bit index never reaches past 4096 entries
    localparam int VD  = (VERTEX_DEPTH > 4096) ? 4096 : VERTEX_DEPTH;
    localparam int VA  = $clog2(VD);
    localparam int SQW = 2 * COORD_BITS + 2;      // squared sum width
    localparam int SQI = (SQW + 1) / 2;           // root iterations
    localparam int SW  = 2 * SQI;
    localparam int PW  = 3 * COORD_BITS;
    localparam int QW  = 21;                      // divide by three product width
    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [PW-1:0] vstore [VD];
    logic [11:0]   istore [CHUNK_LEN];

    logic          op_reg, eol_reg;
    logic [11:0]   idx_reg;
    logic [PW-1:0] rd_reg;
    logic          rd_ok_reg;
    logic [CW-1:0] fill_reg;
    logic [31:0]   offset_reg;
    logic signed [COORD_BITS-1:0] min_reg [3];
    logic signed [COORD_BITS-1:0] max_reg [3];
    logic signed [COORD_BITS-1:0] ctr_reg [3];
    logic [CW-1:0] pass_reg;
    logic [11:0]   pidx_reg;
    logic          pidx_ok_reg;
    logic [PW-1:0] prd_reg;
    logic          prd_ok_reg;
    logic          pv1_reg, pv2_reg, pv3_reg;
    logic [2*COORD_BITS+1:0] sq_reg [3];
    logic [SQW-1:0] best_reg;
    logic [SW-1:0]  rem_reg;
    logic [SQI-1:0] root_reg;
    logic [$clog2(SQI+1)-1:0] it_reg;
    logic [SQW-1:0] val_reg;

    function automatic logic in_range(input logic [11:0] i);
        return {20'd0, i} < VERTEX_DEPTH;
    endfunction

    // fetch stage: store access after latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= op;
            eol_reg <= end_of_list;
            idx_reg <= vertex_index;
            if (op == OP_WRITE && in_range(vertex_index))
                vstore[vertex_index[VA-1:0]] <= {pos_z, pos_y, pos_x};
        end
        rd_reg   <= vstore[idx_reg[VA-1:0]];
        rd_ok_reg <= in_range(idx_reg);
        prd_reg  <= vstore[pidx_reg[VA-1:0]];
        prd_ok_reg <= pidx_ok_reg;
        pidx_reg <= istore[pass_reg[CA-1:0]];
        pidx_ok_reg <= in_range(istore[pass_reg[CA-1:0]]);
        if (cmd.box_update)
            istore[(fill_reg == CW'(CHUNK_LEN)) ? '0 : fill_reg[CA-1:0]] <= idx_reg;
    end

    logic [CW-1:0] fill_base;
    assign fill_base = (fill_reg == CW'(CHUNK_LEN)) ? '0 : fill_reg;

    logic signed [COORD_BITS-1:0] p [3];
    logic signed [COORD_BITS-1:0] pp [3];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            p[a]  = rd_ok_reg  ? rd_reg[a*COORD_BITS +: COORD_BITS] : '0;
            pp[a] = prd_ok_reg ? prd_reg[a*COORD_BITS +: COORD_BITS] : '0;
        end
    end

    // box with the looked-up position folded in
    logic signed [COORD_BITS-1:0] lo_fold [3];
    logic signed [COORD_BITS-1:0] hi_fold [3];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            lo_fold[a] = (p[a] < min_reg[a]) ? p[a] : min_reg[a];
            hi_fold[a] = (p[a] > max_reg[a]) ? p[a] : max_reg[a];
        end
    end

    // center comes from the box including the closing index
    logic signed [COORD_BITS:0] csum [3];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
            csum[a] = {lo_fold[a][COORD_BITS-1], lo_fold[a]}
                      + {hi_fold[a][COORD_BITS-1], hi_fold[a]};
    end

    // box, fill and offset bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            offset_reg <= '0;
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a] <= CMAX;
                max_reg[a] <= CMIN;
            end
        end
        else if (cmd.box_update)
        begin
            fill_reg <= fill_base + 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a] <= lo_fold[a];
                max_reg[a] <= hi_fold[a];
            end
        end
        else if (cmd.finish)
        begin
            offset_reg <= eol_reg ? '0 : offset_reg + 32'(fill_reg);
            fill_reg   <= '0;
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a] <= CMAX;
                max_reg[a] <= CMIN;
            end
        end
    end

    // radius pass: index read, vertex read, square, sum and max
    logic signed [COORD_BITS:0] d [3];
    logic [COORD_BITS:0] m [3];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            d[a] = {pp[a][COORD_BITS-1], pp[a]} - {ctr_reg[a][COORD_BITS-1], ctr_reg[a]};
            m[a] = d[a][COORD_BITS] ? COORD_BITS'(0) - d[a] : d[a];
        end
    end

    logic [SQW-1:0] ssum;
    assign ssum = SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= '0;
            pv1_reg  <= 1'b0;
            pv2_reg  <= 1'b0;
            pv3_reg  <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            pv1_reg <= cmd.pass_step;
            pv2_reg <= pv1_reg;
            pv3_reg <= pv2_reg;
            if (cmd.pass_start)
            begin
                pass_reg <= '0;
                best_reg <= '0;
                for (int a = 0; a < 3; a++)
                    ctr_reg[a] <= csum[a][COORD_BITS:1];
            end
            else
            begin
                if (cmd.pass_step)
                    pass_reg <= pass_reg + 1'b1;
                if (pv3_reg && ssum > best_reg)
                    best_reg <= ssum;
            end
            for (int a = 0; a < 3; a++)
                sq_reg[a] <= SQW'(m[a]) * SQW'(m[a]);
        end
    end

    // restoring square root, one result bit per cycle
    logic [SW-1:0] rem_sh;
    assign rem_sh = {rem_reg[SW-3:0], val_reg[SQW-1 -: 2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            it_reg <= '0;
        else if (cmd.sqrt_start)
        begin
            it_reg   <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            val_reg  <= best_reg;
        end
        else if (cmd.sqrt_step)
        begin
            it_reg  <= it_reg + 1'b1;
            val_reg <= val_reg << 2;
            if (rem_sh >= ((SW'(root_reg) << 2) | SW'(1)))
            begin
                rem_reg  <= rem_sh - ((SW'(root_reg) << 2) | SW'(1));
                root_reg <= {root_reg[SQI-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[SQI-2:0], 1'b0};
            end
        end
    end

    // triangle count: multiply by 683 and drop 11 bits, exact for fills below 2048
    logic [QW-1:0] third_prod;
    assign third_prod = QW'(fill_reg) * QW'(683);

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            prim_offset   <= offset_reg;
            prim_count    <= third_prod[17:11];
            mesh_vertices <= cfg_value;
            center_x      <= ctr_reg[0];
            center_y      <= ctr_reg[1];
            center_z      <= ctr_reg[2];
            radius        <= 26'(root_reg);
        end
    end

    assign status.is_index     = (op_reg == OP_INDEX);
    assign status.meshlet_done = eol_reg || (fill_base + 1'b1 == CW'(CHUNK_LEN));
    assign status.pass_last    = (pass_reg + 1'b1 == fill_reg);
    assign status.sqrt_last    = (it_reg == ($clog2(SQI+1))'(SQI - 1));
endmodule

// ----- rtl/mbs_ctrl.sv -----
// mbs_ctrl: sequencer for index lookup, radius pass, square root and output
// depends on mbs_pkg
module mbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 out_stall,
    output logic                 out_valid,
    output mbs_pkg::mbs_cmd_t    cmd,
    input  mbs_pkg::mbs_status_t status
);
    import mbs_pkg::*;

    mbs_state_t state_reg, state_next;
    logic [1:0] drain_reg, drain_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // let the latched index address the vertex store before the box update
                if (!status.is_index)
                    state_next = ST_IDLE;
                else
                    state_next = ST_PASS;
            end
            ST_PASS:
            begin
                if (drain_reg == 2'd0)
                begin
                    cmd.box_update = 1'b1;
                    if (status.meshlet_done)
                    begin
                        cmd.pass_start = 1'b1;
                        drain_next = 2'd1;
                    end
                    else
                        state_next = ST_IDLE;
                end
                else
                begin
                    cmd.pass_step = 1'b1;
                    if (status.pass_last)
                    begin
                        drain_next = 2'd0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd3)
                begin
                    drain_next = 2'd0;
                    cmd.sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    cmd.finish = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
endmodule

// ----- rtl/meshlet_bounding_sphere.sv -----
// meshlet_bounding_sphere: top level, joins controller and datapath
// depends on mbs_pkg, mbs_ctrl, mbs_datapath
//
// op 0 items write a vertex position as they are latched; op 1 items go
// through latch, vertex store read and box update. an item that closes a
// meshlet adds a radius pass (one stored index per cycle through the index
// store and vertex store reads, then a square and compare pipe) and a
// restoring square root, one result bit a cycle. the result sits in an
// output register; a new item is taken while it waits, and a later result
// waits only for that register to empty.
module meshlet_bounding_sphere #(
    parameter int MAX_TRIANGLES = 126,
    parameter int VERTEX_DEPTH  = 4096,
    parameter int COORD_BITS    = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [11:0]                  vertex_index,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic                         end_of_list,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [31:0]                  prim_offset,
    output logic [6:0]                   prim_count,
    output logic [12:0]                  mesh_vertices,
    output logic signed [COORD_BITS-1:0] center_x,
    output logic signed [COORD_BITS-1:0] center_y,
    output logic signed [COORD_BITS-1:0] center_z,
    output logic [25:0]                  radius,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [12:0]                  cfg_data
);
    import mbs_pkg::*;

    mbs_cmd_t    cmd;
    mbs_status_t status;
    logic [12:0] vcount_reg;

    // vertex count register, always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= '0;
        else if (cfg_valid)
            vcount_reg <= cfg_data;
    end

    mbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .status    (status)
    );

    mbs_datapath #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .VERTEX_DEPTH  (VERTEX_DEPTH),
        .COORD_BITS    (COORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .op            (op),
        .vertex_index  (vertex_index),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .end_of_list   (end_of_list),
        .cfg_value     (vcount_reg),
        .prim_offset   (prim_offset),
        .prim_count    (prim_count),
        .mesh_vertices (mesh_vertices),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .radius        (radius)
    );
endmodule

// ----- rtl/mbs_checker.sv -----
// mbs_checker: port level checks for meshlet_bounding_sphere
// depends on meshlet_bounding_sphere ports only
module mbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] prim_offset,
    input logic [6:0]  prim_count,
    input logic [25:0] radius
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(prim_offset) && $stable(radius))
        else $error("stalled item changed");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> prim_count <= 7'd126)
        else $error("prim_count out of range");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("item repeated");
endmodule

bind meshlet_bounding_sphere mbs_checker u_mbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .prim_offset (prim_offset),
    .prim_count  (prim_count),
    .radius      (radius)
);
